// ===== hw/rtl/lsls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsls_pkg;

    // Field widths fixed by the interface
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned STATUS_W = 2;

    // Item function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_READING = 1'b1;

    // Sensor reading status codes
    localparam logic [STATUS_W-1:0] STATUS_VALID       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ANALOG_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIGITAL_SAT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SENSOR_ERR  = 2'd3;

    // Reset value of the maximum drive level register
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 16'd4095;

    // Lowest level a finished search may report after backing off
    localparam int unsigned MIN_FINAL_LEVEL = 2;

    // Divide by five as multiply and shift; exact for operands below 2^14
    localparam int unsigned DIV5_MUL   = 52429;
    localparam int unsigned DIV5_SHIFT = 18;

    typedef struct packed {
        logic                func;
        logic [STATUS_W-1:0] reading_status;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] led_level;
        logic               done_res;
        logic               failed;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/led_saturation_level_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while result_ready does not stall the result register;
// the search state updates in the same cycle that an item leaves the input register, so
// the next item sees it without a bubble.
// Reset: asynchronous, active low; clears the search to idle, all levels to zero and
// loads the maximum level register with 4095.

module led_saturation_level_search_unit
    import lsls_pkg::*;
#(
    parameter int unsigned LEVEL_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LEVEL_W-1:0] cfg_data,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire item_t              item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_DONE,
        PH_FAIL
    } phase_t;

    localparam int unsigned QUOT_W = LEVEL_BITS + DIV5_SHIFT;

    // Registers
    logic [LEVEL_BITS-1:0] max_level_reg;
    logic [LEVEL_BITS-1:0] cur_level_reg;
    logic [LEVEL_BITS-1:0] cur_level_next;
    logic [LEVEL_BITS-1:0] sat_level_reg;
    logic [LEVEL_BITS-1:0] sat_level_next;
    logic [LEVEL_BITS-1:0] floor_level_reg;
    logic [LEVEL_BITS-1:0] floor_level_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  stage_valid_reg;
    item_t                 stage_item_reg;
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    // Datapath signals
    logic                  advance;
    logic                  fire;
    logic [LEVEL_BITS:0]   up_sum;
    logic [LEVEL_BITS-1:0] upper;
    logic [LEVEL_BITS-1:0] up_level;
    logic signed [LEVEL_BITS:0] diff;
    logic signed [LEVEL_BITS:0] diff_adj;
    logic signed [LEVEL_BITS:0] half;
    logic [LEVEL_BITS-1:0] down_level;
    logic [LEVEL_BITS-1:0] quarter;
    logic [QUOT_W-1:0]     prod;
    logic [LEVEL_BITS-1:0] twentieth;
    logic [LEVEL_BITS-1:0] backoff;
    logic [LEVEL_BITS-1:0] final_level;
    logic                  at_max;
    logic                  below_sat;

    // Advance the stage when the result register is empty or being drained
    assign advance      = !result_valid_reg || result_ready;
    assign fire         = stage_valid_reg && advance;
    assign item_ready   = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Bisect upward toward the saturated level, or the maximum when none seen
    assign upper    = (sat_level_reg == '0) ? max_level_reg : sat_level_reg;
    assign up_sum   = {1'b0, cur_level_reg} + {1'b0, upper};
    assign up_level = up_sum[LEVEL_BITS:1];

    // Bisect downward toward the floor; halve the signed gap toward zero
    assign diff       = $signed({1'b0, cur_level_reg}) - $signed({1'b0, floor_level_reg});
    assign diff_adj   = diff + $signed({{LEVEL_BITS{1'b0}}, diff[LEVEL_BITS]});
    assign half       = diff_adj >>> 1;
    assign down_level = floor_level_reg + half[LEVEL_BITS-1:0];

    // Back off to ceil(level * 0.95) as level - floor(level / 20)
    assign quarter   = cur_level_reg >> 2;
    assign prod      = QUOT_W'(quarter) * QUOT_W'(DIV5_MUL);
    assign twentieth = prod[QUOT_W-1:DIV5_SHIFT];
    assign backoff   = cur_level_reg - twentieth;
    assign final_level = (backoff < LEVEL_BITS'(MIN_FINAL_LEVEL))
                         ? LEVEL_BITS'(MIN_FINAL_LEVEL) : backoff;

    assign at_max    = (cur_level_reg == max_level_reg);
    assign below_sat = (({1'b0, cur_level_reg} + (LEVEL_BITS+1)'(1)) == {1'b0, sat_level_reg});

    // Search step for the transaction held in the input register
    always_comb
    begin
        cur_level_next   = cur_level_reg;
        sat_level_next   = sat_level_reg;
        floor_level_next = floor_level_reg;
        phase_next       = phase_reg;
        result_next      = '0;

        if (stage_item_reg.func == FUNC_START)
        begin
            cur_level_next        = max_level_reg;
            sat_level_next        = '0;
            floor_level_next      = '0;
            phase_next            = PH_SEARCH;
            result_next.led_level = LEVEL_W'(max_level_reg);
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    result_next = '0;
                end
                PH_DONE:
                begin
                    result_next.led_level = LEVEL_W'(cur_level_reg);
                    result_next.done_res  = 1'b1;
                end
                PH_FAIL:
                begin
                    result_next.failed = 1'b1;
                end
                PH_SEARCH:
                begin
                    case (stage_item_reg.reading_status) inside
                        STATUS_VALID:
                        begin
                            if (at_max)
                            begin
                                phase_next            = PH_DONE;
                                result_next.led_level = LEVEL_W'(cur_level_reg);
                                result_next.done_res  = 1'b1;
                            end
                            else if (below_sat)
                            begin
                                cur_level_next        = final_level;
                                phase_next            = PH_DONE;
                                result_next.led_level = LEVEL_W'(final_level);
                                result_next.done_res  = 1'b1;
                            end
                            else
                            begin
                                floor_level_next      = cur_level_reg;
                                cur_level_next        = up_level;
                                result_next.led_level = LEVEL_W'(up_level);
                            end
                        end
                        STATUS_ANALOG_SAT, STATUS_DIGITAL_SAT:
                        begin
                            if (cur_level_reg == '0)
                            begin
                                phase_next         = PH_FAIL;
                                result_next.failed = 1'b1;
                            end
                            else
                            begin
                                sat_level_next = cur_level_reg;
                                if (down_level == cur_level_reg)
                                begin
                                    cur_level_next = down_level - LEVEL_BITS'(1);
                                end
                                else
                                begin
                                    cur_level_next = down_level;
                                end
                                result_next.led_level = LEVEL_W'(cur_level_next);
                            end
                        end
                        default:
                        begin
                            phase_next         = PH_FAIL;
                            result_next.failed = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    // Hold configuration, search state, input stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg    <= LEVEL_BITS'(MAX_LEVEL_RESET);
            cur_level_reg    <= '0;
            sat_level_reg    <= '0;
            floor_level_reg  <= '0;
            phase_reg        <= PH_IDLE;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_level_reg <= cfg_data[LEVEL_BITS-1:0];
            end

            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end

            if (fire)
            begin
                cur_level_reg   <= cur_level_next;
                sat_level_reg   <= sat_level_next;
                floor_level_reg <= floor_level_next;
                phase_reg       <= phase_next;
            end

            if (advance)
            begin
                result_valid_reg <= stage_valid_reg;
            end
        end
    end

    // Load payload registers without reset
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_item_reg <= item;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
